// ===== hdl/tye_pkg.sv =====
// ----------------------------------------------------------------------------
// tye_pkg
// shared types, constants and the arctangent table for the tilt and yaw block
// ----------------------------------------------------------------------------
package tye_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
	localparam int VEC_W        = 52;

	localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

	localparam logic CFG_GRAVITY = 1'b0;
	localparam logic CFG_YAW_GAIN = 1'b1;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_z;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic               roll_clipped;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_ROLL,
		ST_PITCH,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture sample, start square root
		logic sqrt_step; // one root bit pair
		logic roll_init; // set up roll cordic
		logic pitch_init;// save roll, set up pitch cordic
		logic cordic_step;
		logic finish;    // build result word
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sqrt_done;
		logic cordic_done;
	} dp_sts_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0:  r = 32'h20000000;
				5'd1:  r = 32'h12E4051D;
				5'd2:  r = 32'h09FB385B;
				5'd3:  r = 32'h051111D4;
				5'd4:  r = 32'h028B0D43;
				5'd5:  r = 32'h0145D7E1;
				5'd6:  r = 32'h00A2F61E;
				5'd7:  r = 32'h00517C55;
				5'd8:  r = 32'h0028BE53;
				5'd9:  r = 32'h00145F2E;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2F9;
				5'd15: r = 32'h0000517C;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A2F;
				5'd19: r = 32'h00000517;
				5'd20: r = 32'h0000028B;
				5'd21: r = 32'h00000145;
				5'd22: r = 32'h000000A2;
				5'd23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction

	// round a 32-bit turn to the output angle width, then into the field
	function automatic logic [15:0] to_angle(input logic [31:0] a);
		logic [31:0] s;
		logic [31:0] r;
		begin
			s = a + (32'd1 << (31 - ANGLE_BITS));
			r = s >> (32 - ANGLE_BITS);
			return r[15:0];
		end
	endfunction

endpackage

// ===== hdl/tye_ctrl.sv =====
// ----------------------------------------------------------------------------
// tye_ctrl
// sequencer: square root, roll cordic, pitch cordic, result hand-off
// ----------------------------------------------------------------------------
module tye_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  tye_pkg::dp_sts_t   sts,
	output tye_pkg::dp_cmd_t   cmd
);

	tye_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tye_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q & out_stall;
		cmd         = '0;
		in_stall    = 1'b1;
		case (state_q)
			tye_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tye_pkg::ST_SQRT;
				end
			end
			tye_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) begin
					cmd.sqrt_step = 1'b0;
					cmd.roll_init = 1'b1;
					state_d = tye_pkg::ST_ROLL;
				end
			end
			tye_pkg::ST_ROLL: begin
				cmd.cordic_step = 1'b1;
				if (sts.cordic_done) begin
					cmd.cordic_step = 1'b0;
					cmd.pitch_init  = 1'b1;
					state_d = tye_pkg::ST_PITCH;
				end
			end
			tye_pkg::ST_PITCH: begin
				cmd.cordic_step = 1'b1;
				if (sts.cordic_done) begin
					cmd.cordic_step = 1'b0;
					state_d = tye_pkg::ST_DONE;
				end
			end
			tye_pkg::ST_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = tye_pkg::ST_IDLE;
				end
			end
			default: state_d = tye_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/tye_dp.sv =====
// ----------------------------------------------------------------------------
// tye_dp
// datapath: config registers, yaw accumulator, bitwise square root,
// one shared vectoring cordic and the output word register
// ----------------------------------------------------------------------------
module tye_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  tye_pkg::in_word_t    in_word,
	input  tye_pkg::dp_cmd_t     cmd,
	output tye_pkg::dp_sts_t     sts,
	output tye_pkg::out_word_t   out_word
);

	localparam int VW = tye_pkg::VEC_W;
	localparam int SC = 32 - tye_pkg::SAMPLE_BITS;

	logic [14:0]        grav_q;
	logic signed [15:0] gain_q;
	logic [31:0]        yaw_q;

	logic signed [15:0] ay_q, az_q;
	logic signed [16:0] num_q;
	logic               clip_q;

	// square root state
	logic [31:0] rem_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;

	// cordic state
	logic signed [VW-1:0] vx_q, vy_q;
	logic [31:0]          ang_q;
	logic [tye_pkg::STEP_W-1:0] step_q;
	logic                 bypass_q;
	logic [31:0]          roll_q;

	logic [14:0] g_eff;
	logic [16:0] mag;
	logic [31:0] g_sq, n_sq;
	logic signed [31:0] inc;
	logic [31:0] trial;
	logic signed [VW-1:0] dx, dy;
	logic [4:0]  tab_idx;

	// special-case evaluation shared by both arctangents
	logic signed [16:0] ey, ex;
	logic               e_byp;
	logic [31:0]        e_ang;
	logic signed [VW-1:0] e_vx, e_vy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 15'd16384;
			gain_q <= 16'sd1024;
			yaw_q  <= '0;
		end else begin
			if (cfg_wr && cfg_index == tye_pkg::CFG_GRAVITY) grav_q <= cfg_data[14:0];
			if (cfg_wr && cfg_index == tye_pkg::CFG_YAW_GAIN) gain_q <= cfg_data;
			if (cmd.load) yaw_q <= yaw_q + inc;
		end
	end

	assign inc   = in_word.gyro_z * gain_q;
	assign g_eff = (grav_q == '0) ? 15'd1 : grav_q;
	assign mag   = in_word.accel_x[15] ? -{in_word.accel_x[15], in_word.accel_x}
	                                   : {in_word.accel_x[15], in_word.accel_x};
	assign g_sq  = g_eff * g_eff;
	assign n_sq  = mag * mag;
	assign trial = res_q + bit_q;

	// sample capture and square root; one bit pair per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ay_q   <= in_word.accel_y;
			az_q   <= in_word.accel_z;
			num_q  <= -{in_word.accel_x[15], in_word.accel_x};
			clip_q <= mag > {2'b0, g_eff};
			rem_q  <= (mag > {2'b0, g_eff}) ? 32'd0 : g_sq - n_sq;
			res_q  <= '0;
			bit_q  <= 32'h4000_0000;
		end else if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign sts.sqrt_done = (bit_q == '0);

	// operands of the next arctangent
	always_comb begin
		if (cmd.roll_init) begin
			ey = num_q;
			ex = {1'b0, res_q[15:0]};
		end else begin
			ey = {ay_q[15], ay_q};
			ex = {az_q[15], az_q};
		end
		e_byp = 1'b1;
		e_ang = '0;
		e_vx  = VW'(ex) <<< SC;
		e_vy  = VW'(ey) <<< SC;
		if (ey == 0) begin
			e_ang = (ex < 0) ? tye_pkg::TURN_HALF : 32'd0;
		end else if (ex == 0) begin
			e_ang = (ey > 0) ? tye_pkg::TURN_QUARTER : -tye_pkg::TURN_QUARTER;
		end else begin
			e_byp = 1'b0;
			if (ex < 0) begin
				e_vx  = -e_vx;
				e_vy  = -e_vy;
				e_ang = tye_pkg::TURN_HALF;
			end
		end
		if (cmd.roll_init && clip_q) begin
			e_byp = 1'b1;
			e_ang = (num_q > 0) ? tye_pkg::TURN_QUARTER : -tye_pkg::TURN_QUARTER;
		end
	end

	assign tab_idx = 5'(step_q);
	assign dx = vy_q >>> step_q;
	assign dy = vx_q >>> step_q;

	always_ff @(posedge clk) begin
		if (cmd.roll_init || cmd.pitch_init) begin
			vx_q     <= e_vx;
			vy_q     <= e_vy;
			ang_q    <= e_ang;
			bypass_q <= e_byp;
			step_q   <= '0;
			if (cmd.pitch_init) roll_q <= ang_q;
		end else if (cmd.cordic_step) begin
			if (!bypass_q) begin
				if (!vy_q[VW-1]) begin
					vx_q  <= vx_q + dx;
					vy_q  <= vy_q - dy;
					ang_q <= ang_q + tye_pkg::atan_turn(tab_idx);
				end else begin
					vx_q  <= vx_q - dx;
					vy_q  <= vy_q + dy;
					ang_q <= ang_q - tye_pkg::atan_turn(tab_idx);
				end
			end
			step_q <= step_q + 1'b1;
		end
	end

	assign sts.cordic_done = bypass_q ||
	                         (step_q == tye_pkg::STEP_W'(tye_pkg::CORDIC_STEPS));

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_word.roll_angle   <= tye_pkg::to_angle(roll_q);
			out_word.pitch_angle  <= tye_pkg::to_angle(ang_q);
			out_word.yaw_angle    <= yaw_q[31:16];
			out_word.roll_clipped <= clip_q;
		end
	end

endmodule

// ===== hdl/tilt_and_yaw_estimator.sv =====
// ----------------------------------------------------------------------------
// tilt_and_yaw_estimator
// roll, pitch and yaw from one accelerometer and gyro sample
// ----------------------------------------------------------------------------
// One word in gives one word out. Roll is asin(-accel_x / gravity_counts),
// clamped to a quarter turn with roll_clipped set when |accel_x| exceeds
// gravity; pitch is atan2(accel_y, accel_z); yaw is the top half of a 32-bit
// wrapping accumulator that adds gyro_z * yaw_gain per word. Angles are binary
// angles (full 16-bit range = one turn). A word is accepted, then goes through
// the bit-pair square root (16 bit pairs) and the two vectoring cordic passes
// run on one shared unit (16 steps each; axis-aligned cases skip the steps),
// and then the output register is loaded. A receiver still holding the
// previous result holds off the loading of the output register. The output
// register holds the result while the next word is accepted. The user must
// write configuration through cfg_wr / cfg_index / cfg_data only while the
// block is idle; the block itself has no check for it.
module tilt_and_yaw_estimator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tye_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tye_pkg::out_word_t   out_word
);

	tye_pkg::dp_cmd_t cmd;
	tye_pkg::dp_sts_t sts;

	// sequencer
	tye_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and state
	tye_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_word  (out_word)
	);

endmodule
